@@ src/rmcp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmcp_pkg
// Shared types and constants of the RMC sentence parser.
// ----------------------------------------------------------------------------
package rmcp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_TO_COMMA,
		PH_BODY,
		PH_CK1,
		PH_CK2
	} phase_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_FIX    = 8'h41; // 'A'
	localparam logic [7:0] CH_SOUTH  = 8'h53; // 'S'
	localparam logic [7:0] CH_WEST   = 8'h57; // 'W'

	localparam int unsigned MIN_W = 24; // minute accumulator, covers up to 5 fraction digits

	localparam logic [27:0] LAT_LIMIT = 28'd90000000;
	localparam logic [27:0] LON_LIMIT = 28'd180000000;

	localparam logic [4:0] ZONE_HOURS_RST   = 5'd5;
	localparam logic [5:0] ZONE_MINUTES_RST = 6'd30;

	localparam logic CFG_ZONE_HOURS   = 1'b0;
	localparam logic CFG_ZONE_MINUTES = 1'b1;

	// raw sentence fields handed from the front to the back
	typedef struct packed {
		logic [6:0]       hours;
		logic [6:0]       minutes;
		logic [6:0]       seconds;
		logic [6:0]       day;
		logic [6:0]       month;
		logic [6:0]       year;
		logic             fix;
		logic [6:0]       lat_deg;
		logic [MIN_W-1:0] lat_min;
		logic             south;
		logic [7:0]       lon_deg;
		logic [MIN_W-1:0] lon_min;
		logic             west;
		logic [7:0]       cksum;
	} rmc_rec_t;

	function automatic logic [23:0] pow10(input logic [2:0] n);
		logic [23:0] r;
		unique case (n)
			3'd0: r = 24'd1;
			3'd1: r = 24'd10;
			3'd2: r = 24'd100;
			3'd3: r = 24'd1000;
			3'd4: r = 24'd10000;
			3'd5: r = 24'd100000;
			3'd6: r = 24'd1000000;
			default: r = 24'd10000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/rmcp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmcp_front
// Byte parser: header match, field split, per-character accumulation.
// ----------------------------------------------------------------------------
module rmcp_front import rmcp_pkg::*; #(
	parameter int unsigned FRAC_DIGITS = 4,
	parameter int unsigned FIELD_CHARS = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     take,
	input  wire logic [7:0] c,
	output logic          push,
	output rmc_rec_t      rec
);

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_q;
	logic [3:0]  field_q, char_q;
	logic [3:0]  t_dig_q [6];
	logic [3:0]  d_dig_q [6];
	logic        fix_q, south_q, west_q;
	logic [6:0]  lat_deg_q;
	logic [7:0]  lon_deg_q;
	logic [MIN_W-1:0] lat_min_q, lon_min_q;
	logic [7:0]  ck_q;

	logic [3:0]  d;
	logic [3:0]  hx;
	logic [7:0]  hdr_ch;
	logic        hdr_ok;
	logic        in_field;
	logic [7:0]  lat_v;
	logic [10:0] lon_v;
	logic [23:0] lat_w, lon_w;

	function automatic logic [23:0] min_weight(input logic [3:0] q);
		logic [23:0] w;
		if (q == 4'd0)
			w = pow10(3'(FRAC_DIGITS + 1));
		else if (q == 4'd1)
			w = pow10(3'(FRAC_DIGITS));
		else if (q >= 4'd3 && (q - 4'd2) <= 4'(FRAC_DIGITS))
			w = pow10(3'(4'(FRAC_DIGITS) - (q - 4'd2)));
		else
			w = '0;
		return w;
	endfunction

	function automatic logic [6:0] two_dig(input logic [3:0] a, input logic [3:0] b);
		return 7'(a) * 7'd10 + 7'(b);
	endfunction

	always_comb begin
		d = (c >= 8'h30 && c <= 8'h39) ? c[3:0] : 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			hx = c[3:0];
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			hx = c[3:0] + 4'd9;
		else
			hx = 4'd0;
	end

	always_comb begin
		unique case (hdr_q)
			3'd0: hdr_ch = 8'h47; // G
			3'd1: hdr_ch = 8'h50; // P
			3'd2: hdr_ch = 8'h52; // R
			3'd3: hdr_ch = 8'h4D; // M
			3'd4: hdr_ch = 8'h43; // C
			default: hdr_ch = 8'h00;
		endcase
		hdr_ok = (hdr_q < 3'd5) && (c == hdr_ch);
	end

	assign in_field = char_q < 4'(FIELD_CHARS);
	assign lat_v = 8'(lat_deg_q) + ((char_q == 4'd0) ? 8'(d) * 8'd10 : 8'(d));
	assign lon_v = 11'(lon_deg_q) + 11'(d) * 11'(pow10(3'(4'd2 - char_q)));
	assign lat_w = min_weight(char_q - 4'd2);
	assign lon_w = min_weight(char_q - 4'd3);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (c == CH_DOLLAR) begin
			phase_d = PH_HEADER;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (!hdr_ok)
						phase_d = PH_IDLE;
					else if (hdr_q == 3'd4)
						phase_d = PH_TO_COMMA;
				end
				PH_TO_COMMA: if (c == CH_COMMA) phase_d = PH_BODY;
				PH_BODY:     if (c == CH_STAR) phase_d = PH_CK1;
				PH_CK1:      phase_d = PH_CK2;
				PH_CK2:      phase_d = PH_IDLE;
				default:     phase_d = PH_IDLE;
			endcase
		end
	end

	// word out to the queue
	always_comb begin
		push = take && (c != CH_DOLLAR) && (phase_q == PH_CK2);
		rec.hours   = two_dig(t_dig_q[0], t_dig_q[1]);
		rec.minutes = two_dig(t_dig_q[2], t_dig_q[3]);
		rec.seconds = two_dig(t_dig_q[4], t_dig_q[5]);
		rec.day     = two_dig(d_dig_q[0], d_dig_q[1]);
		rec.month   = two_dig(d_dig_q[2], d_dig_q[3]);
		rec.year    = two_dig(d_dig_q[4], d_dig_q[5]);
		rec.fix     = fix_q;
		rec.lat_deg = lat_deg_q;
		rec.lat_min = lat_min_q;
		rec.south   = south_q;
		rec.lon_deg = lon_deg_q;
		rec.lon_min = lon_min_q;
		rec.west    = west_q;
		rec.cksum   = {ck_q[7:4], hx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hdr_q     <= '0;
			field_q   <= '0;
			char_q    <= '0;
			t_dig_q   <= '{default: '0};
			d_dig_q   <= '{default: '0};
			fix_q     <= 1'b0;
			south_q   <= 1'b0;
			west_q    <= 1'b0;
			lat_deg_q <= '0;
			lon_deg_q <= '0;
			lat_min_q <= '0;
			lon_min_q <= '0;
			ck_q      <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			if (c == CH_DOLLAR) begin
				hdr_q     <= '0;
				field_q   <= '0;
				char_q    <= '0;
				t_dig_q   <= '{default: '0};
				d_dig_q   <= '{default: '0};
				fix_q     <= 1'b0;
				south_q   <= 1'b0;
				west_q    <= 1'b0;
				lat_deg_q <= '0;
				lon_deg_q <= '0;
				lat_min_q <= '0;
				lon_min_q <= '0;
				ck_q      <= '0;
			end else begin
				unique case (phase_q)
					PH_HEADER: if (hdr_ok) hdr_q <= hdr_q + 3'd1;
					PH_BODY: begin
						if (c == CH_COMMA) begin
							if (field_q != 4'd15) field_q <= field_q + 4'd1;
							char_q <= '0;
						end else if (c != CH_STAR) begin
							if (char_q != 4'd15) char_q <= char_q + 4'd1;
							if (in_field) begin
								unique case (field_q)
									4'd0: if (char_q < 4'd6) t_dig_q[char_q[2:0]] <= d;
									4'd1: if (char_q == 4'd0) fix_q <= (c == CH_FIX);
									4'd2: begin
										if (char_q < 4'd2)
											lat_deg_q <= (lat_v > 8'd90) ? 7'd90 : lat_v[6:0];
										else
											lat_min_q <= lat_min_q + MIN_W'(d) * lat_w;
									end
									4'd3: if (char_q == 4'd0 && c == CH_SOUTH) south_q <= 1'b1;
									4'd4: begin
										if (char_q < 4'd3)
											lon_deg_q <= (lon_v > 11'd180) ? 8'd180 : lon_v[7:0];
										else
											lon_min_q <= lon_min_q + MIN_W'(d) * lon_w;
									end
									4'd5: if (char_q == 4'd0 && c == CH_WEST) west_q <= 1'b1;
									4'd8: if (char_q < 4'd6) d_dig_q[char_q[2:0]] <= d;
									default: ;
								endcase
							end
						end
					end
					PH_CK1: ck_q <= {hx, 4'd0};
					PH_CK2: ck_q <= {ck_q[7:4], hx};
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ src/rmcp_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmcp_fifo
// Two-entry queue of parsed sentences between front and back.
// ----------------------------------------------------------------------------
module rmcp_fifo import rmcp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  rmc_rec_t      wdata,
	input  wire logic     pop,
	output rmc_rec_t      rdata,
	output logic          full,
	output logic          empty
);

	rmc_rec_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

@@ src/rmcp_coord.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmcp_coord
// Degrees and scaled minutes to saturated microdegrees, three stages.
// ----------------------------------------------------------------------------
module rmcp_coord import rmcp_pkg::*; #(
	parameter int unsigned FRAC_DIGITS = 4
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [7:0]       deg,
	input  wire logic [MIN_W-1:0] min_acc,
	input  wire logic [27:0]      limit,
	output logic [27:0]           udeg
);

	// floor(x/60) = floor(floor(x/4) * M / 2^29) for x < 1e8
	localparam logic [25:0] RECIP = 26'd35791395;

	logic [26:0] x_s1;
	logic [7:0]  deg_s1, deg_s2;
	logic [20:0] q_s2;
	logic [50:0] prod;
	logic [27:0] total;

	assign prod  = 51'(x_s1[26:2]) * 51'(RECIP);
	assign total = 28'(deg_s2) * 28'd1000000 + 28'(q_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= 27'(min_acc) * 27'(pow10(3'(6 - FRAC_DIGITS)));
			deg_s1 <= deg;
			q_s2   <= prod[49:29];
			deg_s2 <= deg_s1;
			udeg   <= (total > limit) ? limit : total;
		end
	end

endmodule
`default_nettype wire

@@ src/rmcp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmcp_back
// Zone shift of the time, coordinate conversion and result register.
// ----------------------------------------------------------------------------
module rmcp_back import rmcp_pkg::*; #(
	parameter int unsigned FRAC_DIGITS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data,
	input  wire logic       q_empty,
	input  rmc_rec_t        q_rec,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      local_hours,
	output logic [5:0]      local_minutes,
	output logic [6:0]      utc_seconds,
	output logic [6:0]      day_of_month,
	output logic [6:0]      month_number,
	output logic [6:0]      year_two_digit,
	output logic            fix_valid,
	output logic [26:0]     latitude_udeg,
	output logic            lat_south,
	output logic [27:0]     longitude_udeg,
	output logic            lon_west,
	output logic [7:0]      received_checksum
);

	logic [4:0] zh_q;
	logic [5:0] zm_q;
	logic       v_s1, v_s2, v_s3;
	logic       en;
	rmc_rec_t   r_s1, r_s2, r_s3;
	logic [4:0] hr_s1, hr_s2, hr_s3;
	logic [5:0] mn_s1, mn_s2, mn_s3;

	logic [7:0] msum, mmod, hsum, hmod;
	logic [1:0] carry;
	logic [27:0] lat_u, lon_u;

	assign en    = !(v_s3 && !out_ready);
	assign q_pop = en && !q_empty;

	always_comb begin
		msum = 8'(q_rec.minutes) + 8'(zm_q);
		if (msum >= 8'd120) begin
			carry = 2'd2; mmod = msum - 8'd120;
		end else if (msum >= 8'd60) begin
			carry = 2'd1; mmod = msum - 8'd60;
		end else begin
			carry = 2'd0; mmod = msum;
		end
		hsum = 8'(q_rec.hours) + 8'(zh_q) + 8'(carry);
		priority if (hsum >= 8'd120) hmod = hsum - 8'd120;
		else if (hsum >= 8'd96) hmod = hsum - 8'd96;
		else if (hsum >= 8'd72) hmod = hsum - 8'd72;
		else if (hsum >= 8'd48) hmod = hsum - 8'd48;
		else if (hsum >= 8'd24) hmod = hsum - 8'd24;
		else hmod = hsum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zh_q <= ZONE_HOURS_RST;
			zm_q <= ZONE_MINUTES_RST;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ZONE_HOURS:   zh_q <= cfg_data[4:0];
					CFG_ZONE_MINUTES: zm_q <= cfg_data;
					default: ;
				endcase
			end
			if (en) begin
				v_s1 <= q_pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1  <= q_rec;
			hr_s1 <= hmod[4:0];
			mn_s1 <= mmod[5:0];
			r_s2  <= r_s1;
			hr_s2 <= hr_s1;
			mn_s2 <= mn_s1;
			r_s3  <= r_s2;
			hr_s3 <= hr_s2;
			mn_s3 <= mn_s2;
		end
	end

	rmcp_coord #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat (
		.clk     (clk),
		.en      (en),
		.deg     ({1'b0, q_rec.lat_deg}),
		.min_acc (q_rec.lat_min),
		.limit   (LAT_LIMIT),
		.udeg    (lat_u)
	);

	rmcp_coord #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon (
		.clk     (clk),
		.en      (en),
		.deg     (q_rec.lon_deg),
		.min_acc (q_rec.lon_min),
		.limit   (LON_LIMIT),
		.udeg    (lon_u)
	);

	assign out_valid         = v_s3;
	assign local_hours       = hr_s3;
	assign local_minutes     = mn_s3;
	assign utc_seconds       = r_s3.seconds;
	assign day_of_month      = r_s3.day;
	assign month_number      = r_s3.month;
	assign year_two_digit    = r_s3.year;
	assign fix_valid         = r_s3.fix;
	assign latitude_udeg     = r_s3.fix ? lat_u[26:0] : 27'd0;
	assign lat_south         = r_s3.fix & r_s3.south;
	assign longitude_udeg    = r_s3.fix ? lon_u : 28'd0;
	assign lon_west          = r_s3.fix & r_s3.west;
	assign received_checksum = r_s3.cksum;

endmodule
`default_nettype wire

@@ src/nmea_rmc_sentence_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// NMEA RMC sentence parser with time zone shift and microdegree output.
//
// Input channel (in_valid/in_ready, rx_byte) takes one character per cycle.
// The front parser consumes each word in the cycle it is accepted; a sentence
// finishes on the second checksum character and its fields go to a two-entry
// queue. The back end pulls from the queue into a three-stage pipeline
// (minute scaling, reciprocal multiply, add and saturate); the last stage is
// the output register. A finished sentence is queued, then runs the stages to
// out_valid. Throughput is one byte per cycle; in_ready drops only when the
// queue is full, which happens only if the receiver holds out_ready low.
// A stalled output freezes the back pipeline; the queue keeps absorbing up
// to two more sentences. Reset clears the parser to idle (waiting for '$'),
// empties the queue and sets the zone to +5h30m. Zone registers are written
// through cfg_we/cfg_index/cfg_data, index 0 hours and 1 minutes.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser import rmcp_pkg::*; #(
	parameter int unsigned MINUTE_FRACTION_DIGITS = 4,
	parameter int unsigned FIELD_CHARS            = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      local_hours,
	output logic [5:0]      local_minutes,
	output logic [6:0]      utc_seconds,
	output logic [6:0]      day_of_month,
	output logic [6:0]      month_number,
	output logic [6:0]      year_two_digit,
	output logic            fix_valid,
	output logic [26:0]     latitude_udeg,
	output logic            lat_south,
	output logic [27:0]     longitude_udeg,
	output logic            lon_west,
	output logic [7:0]      received_checksum
);

	logic     take, push, pop, full, empty;
	rmc_rec_t f_rec, q_rec;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	rmcp_front #(
		.FRAC_DIGITS (MINUTE_FRACTION_DIGITS),
		.FIELD_CHARS (FIELD_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.c      (rx_byte),
		.push   (push),
		.rec    (f_rec)
	);

	rmcp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_rec),
		.pop    (pop),
		.rdata  (q_rec),
		.full   (full),
		.empty  (empty)
	);

	rmcp_back #(.FRAC_DIGITS(MINUTE_FRACTION_DIGITS)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.q_empty           (empty),
		.q_rec             (q_rec),
		.q_pop             (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.local_hours       (local_hours),
		.local_minutes     (local_minutes),
		.utc_seconds       (utc_seconds),
		.day_of_month      (day_of_month),
		.month_number      (month_number),
		.year_two_digit    (year_two_digit),
		.fix_valid         (fix_valid),
		.latitude_udeg     (latitude_udeg),
		.lat_south         (lat_south),
		.longitude_udeg    (longitude_udeg),
		.lon_west          (lon_west),
		.received_checksum (received_checksum)
	);

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the RMC sentence parser. Directed sentences cover the field
// extremes, saturation, lost fix, foreign headers, restarts and bad checksum
// characters. Random sentences mixed with line noise follow, under several
// zone settings. A scoreboard class models the parser byte by byte and checks
// every word that leaves the block, with random stalls on both sides.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [4:0]  hours;
	logic [5:0]  minutes;
	logic [6:0]  seconds;
	logic [6:0]  day;
	logic [6:0]  month;
	logic [6:0]  year;
	logic        fix;
	logic [26:0] lat;
	logic        south;
	logic [27:0] lon;
	logic        west;
	logic [7:0]  cksum;
} rmc_fix_t;

class rmc_scoreboard;
	int unsigned zone_h = 5, zone_m = 30;
	rmcp_pkg::phase_t ph = rmcp_pkg::PH_IDLE;
	int unsigned hpos, fld, pos, tacc, dacc, stat, latd, latm, lond, lonm, ck;
	bit south, west;
	rmc_fix_t fixes_due[$];
	int errors;
	string hdr = "GPRMC";
	int unsigned dec_w[6] = '{100000, 10000, 1000, 100, 10, 1};

	function void clear_all();
		hpos = 0; fld = 0; pos = 0; tacc = 0; dacc = 0; stat = 0;
		latd = 0; latm = 0; lond = 0; lonm = 0; ck = 0; south = 0; west = 0;
	endfunction

	function int unsigned dig(logic [7:0] c);
		return (c >= "0" && c <= "9") ? c - "0" : 0;
	endfunction

	function int unsigned hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - 48;
		if (c >= "A" && c <= "F") return c - 55;
		if (c >= "a" && c <= "f") return c - 87;
		return 0;
	endfunction

	// weight of the q-th minute character, dot position excluded
	function int unsigned min_w(int unsigned q);
		if (q == 0) return 100000;
		if (q == 1) return 10000;
		if (q >= 3 && q <= 6) return dec_w[q - 1];
		return 0;
	endfunction

	function longint unsigned udeg(int unsigned deg, int unsigned mn, longint unsigned lim);
		longint unsigned t;
		t = longint'(deg) * 1000000 + (longint'(mn) * 1000000) / 600000;
		return t > lim ? lim : t;
	endfunction

	function void field_char(logic [7:0] c);
		int unsigned d, v;
		d = dig(c);
		if (pos >= 10) return;
		case (fld)
			0: if (pos < 6) tacc += d * dec_w[pos];
			1: if (pos == 0) stat = c;
			2: if (pos < 2) begin
				v = latd + d * (pos == 0 ? 10 : 1);
				latd = v > 90 ? 90 : v;
			end else latm += d * min_w(pos - 2);
			3: if (pos == 0 && c == rmcp_pkg::CH_SOUTH) south = 1;
			4: if (pos < 3) begin
				v = lond + d * dec_w[3 + pos];
				lond = v > 180 ? 180 : v;
			end else lonm += d * min_w(pos - 3);
			5: if (pos == 0 && c == rmcp_pkg::CH_WEST) west = 1;
			8: if (pos < 6) dacc += d * dec_w[pos];
			default: ;
		endcase
	endfunction

	function void finish_fix();
		rmc_fix_t r;
		int unsigned msum;
		bit fx;
		msum = (tacc / 100) % 100 + zone_m;
		fx = (stat == rmcp_pkg::CH_FIX);
		r.hours = (tacc / 10000 + zone_h + msum / 60) % 24;
		r.minutes = msum % 60;
		r.seconds = tacc % 100;
		r.day = dacc / 10000;
		r.month = (dacc / 100) % 100;
		r.year = dacc % 100;
		r.fix = fx;
		r.lat = fx ? udeg(latd, latm, 90000000) : 0;
		r.south = fx & south;
		r.lon = fx ? udeg(lond, lonm, 180000000) : 0;
		r.west = fx & west;
		r.cksum = ck;
		fixes_due.push_back(r);
	endfunction

	function void note_byte(logic [7:0] c);
		if (c == rmcp_pkg::CH_DOLLAR) begin
			clear_all();
			ph = rmcp_pkg::PH_HEADER;
			return;
		end
		case (ph)
			rmcp_pkg::PH_HEADER: begin
				if (hpos < 5 && c == hdr[hpos]) begin
					hpos++;
					if (hpos == 5) ph = rmcp_pkg::PH_TO_COMMA;
				end else ph = rmcp_pkg::PH_IDLE;
			end
			rmcp_pkg::PH_TO_COMMA: if (c == rmcp_pkg::CH_COMMA) ph = rmcp_pkg::PH_BODY;
			rmcp_pkg::PH_BODY: begin
				if (c == rmcp_pkg::CH_COMMA) begin
					if (fld < 15) fld++;
					pos = 0;
				end else if (c == rmcp_pkg::CH_STAR) ph = rmcp_pkg::PH_CK1;
				else begin
					field_char(c);
					if (pos < 15) pos++;
				end
			end
			rmcp_pkg::PH_CK1: begin
				ck = hex_val(c) << 4;
				ph = rmcp_pkg::PH_CK2;
			end
			rmcp_pkg::PH_CK2: begin
				ck = (ck & 8'hF0) | hex_val(c);
				ph = rmcp_pkg::PH_IDLE;
				finish_fix();
			end
			default: ph = rmcp_pkg::PH_IDLE;
		endcase
	endfunction

	function void cmp(string name, longint unsigned e, longint unsigned a);
		if (e != a) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	function void check_fix(rmc_fix_t a);
		rmc_fix_t e;
		if (fixes_due.size() == 0) begin
			$display("%0t unexpected word: expected none actual %h", $time, a);
			errors++;
			return;
		end
		e = fixes_due.pop_front();
		cmp("local_hours", e.hours, a.hours);
		cmp("local_minutes", e.minutes, a.minutes);
		cmp("utc_seconds", e.seconds, a.seconds);
		cmp("day_of_month", e.day, a.day);
		cmp("month_number", e.month, a.month);
		cmp("year_two_digit", e.year, a.year);
		cmp("fix_valid", e.fix, a.fix);
		cmp("latitude_udeg", e.lat, a.lat);
		cmp("lat_south", e.south, a.south);
		cmp("longitude_udeg", e.lon, a.lon);
		cmp("lon_west", e.west, a.west);
		cmp("received_checksum", e.cksum, a.cksum);
	endfunction
endclass

module tb;
	import rmcp_pkg::*;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0, cfg_index = 0;
	logic [5:0] cfg_data = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [7:0] rx_byte = 0;
	logic [4:0] local_hours;
	logic [5:0] local_minutes;
	logic [6:0] utc_seconds, day_of_month, month_number, year_two_digit;
	logic fix_valid, lat_south, lon_west;
	logic [26:0] latitude_udeg;
	logic [27:0] longitude_udeg;
	logic [7:0] received_checksum;

	rmc_scoreboard sb = new();
	logic [7:0] tx_q[$];
	int unsigned bytes_sent, fixes_seen, idle_cycles;
	bit no_gaps, long_hold;

	nmea_rmc_sentence_parser i_dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_fix({local_hours, local_minutes, utc_seconds, day_of_month,
				month_number, year_two_digit, fix_valid, latitude_udeg, lat_south,
				longitude_udeg, lon_west, received_checksum});
			fixes_seen++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles == 4000) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, and one long hold-off on request
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			if (long_hold) begin
				long_hold = 0;
				stall = 400;
			end
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_queue();
		int unsigned gap;
		logic [7:0] c;
		while (tx_q.size() > 0) begin
			c = tx_q.pop_front();
			gap = no_gaps ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1;
			rx_byte <= c;
			do @(posedge clk); while (!in_ready);
			sb.note_byte(c);
			bytes_sent++;
		end
	endtask

	task automatic push_text(string s);
		foreach (s[k]) tx_q.push_back(s[k]);
	endtask

	// mostly digits, now and then any byte at all
	task automatic push_digits(int unsigned n);
		repeat (n)
			tx_q.push_back($urandom_range(0, 19) == 0 ? 8'($urandom) :
				8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic push_sentence();
		string hx = "0123456789ABCDEFabcdef";
		push_text($urandom_range(0, 9) == 0 ? "$GPRMCxy," : "$GPRMC,");
		push_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 6);
		push_text($urandom_range(0, 3) == 0 ? ",V," : ",A,");
		push_digits(4);
		push_text(".");
		push_digits($urandom_range(0, 7));
		push_text($urandom_range(0, 1) ? ",S," : ",N,");
		push_digits(5);
		push_text(".");
		push_digits($urandom_range(0, 7));
		push_text($urandom_range(0, 1) ? ",W," : ",E,");
		push_digits($urandom_range(0, 4));
		push_text(",");
		push_digits($urandom_range(0, 4));
		push_text(",");
		push_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 6);
		repeat ($urandom_range(0, 3)) push_text(",");
		push_text("*");
		repeat (2)
			tx_q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) :
				8'(hx[$urandom_range(0, 21)]));
		if ($urandom_range(0, 5) == 0) push_text("\r\n");
	endtask

	task automatic push_noise();
		case ($urandom_range(0, 3))
			0: repeat ($urandom_range(1, 6)) tx_q.push_back(8'($urandom));
			1: push_text("$GPGGA,1,2,3*45");
			2: begin
				push_text("$GPRMC,");
				push_digits($urandom_range(0, 8));
			end
			default: push_text("$GPR");
		endcase
	endtask

	task automatic write_zone(int unsigned h, int unsigned m);
		in_valid <= 0;
		wait (sb.fixes_due.size() == 0);
		repeat (8) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= CFG_ZONE_HOURS;
		cfg_data <= 6'(h);
		@(posedge clk);
		cfg_index <= CFG_ZONE_MINUTES;
		cfg_data <= 6'(m);
		@(posedge clk);
		cfg_we <= 0;
		sb.zone_h = h;
		sb.zone_m = m;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes and saturation, lost fix, foreign header, restart
		push_text("$GPRMC,235959,A,9959.9999,S,19959.99999,W,,,311299,,*FF");
		push_text("$GPRMC,000000,V,4807.038,N,01131.000,E,,,230394,,*0a");
		push_text("$GPGGA,123519,A,4807.038,N*47");
		push_text("$GPRMCXX,120000,A,1234.5678,N,12345.6789,E,,,010100*zz");
		push_text("$GPRMC,12$GPRMC,1,A,1,S,1,W*3b");
		push_text("$GPRMC,123456789012,A,12x4.567890123,S,0012+.5,W,,,,,,,,,,,,,,,,,*cD");
		push_text("$GPRMC,083000,A,8959.99,N,17959.9,E,,,0$GPRMC,,,,,,,,,*Gg");
		push_text("$GPRMC,093000,A,0000.0000,N,00000.0000,E,1.2,3.4,150615,,,A*9e\r\n");
		send_queue();
		write_zone(0, 0);
		send_queue();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_zone(23, 59);
				1: write_zone(0, 0);
				default: write_zone($urandom_range(0, 23), $urandom_range(0, 59));
			endcase
			if (ph == 5) begin
				// fill the block while the output is held off
				long_hold = 1;
				no_gaps = 1;
				repeat (8) push_sentence();
				send_queue();
			end
			while (bytes_sent < (ph + 1) * 300 || fixes_seen + sb.fixes_due.size() < (ph + 1) * 4)
			begin
				no_gaps = $urandom_range(0, 3) == 0;
				if ($urandom_range(0, 4) == 0) push_noise();
				else push_sentence();
				send_queue();
			end
		end
		in_valid <= 0;
		wait (sb.fixes_due.size() == 0);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
